@@ sv/aden_pkg.sv @@
// ----------------------------------------------------------------------------
// aden_pkg
// Shared types, constants and saturating fixed-point helpers for the
// acceleration-to-displacement estimator.
// ----------------------------------------------------------------------------
package aden_pkg;

  localparam int STATE_W    = 48;  // internal signed value width
  localparam int FRAC_W     = 16;  // fraction bits of internal values
  localparam int SMP_W      = 16;  // acceleration sample width
  localparam int OUT_W      = 24;  // displacement result width
  localparam int COEF_W     = 16;  // multiplier coefficient port width
  localparam int PROD_W     = STATE_W + COEF_W;
  localparam int GAIN_W     = 15;  // Q0.15 gain and pole
  localparam int STEP_W     = 16;  // Q0.16 integration factors
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SHIFT_Q15  = 15;
  localparam int SHIFT_Q16  = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HPF_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HPF_POLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_TO_VEL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_TO_DISP = 2'd3;

  // reset values of the registers
  localparam logic [GAIN_W-1:0] RST_HPF_GAIN    = 15'd32162;
  localparam logic [GAIN_W-1:0] RST_HPF_POLE    = 15'd31556;
  localparam logic [STEP_W-1:0] RST_ACC_TO_VEL  = 16'd6429;
  localparam logic [STEP_W-1:0] RST_VEL_TO_DISP = 16'd655;

  typedef logic signed [STATE_W-1:0] state_t;
  typedef logic signed [SMP_W-1:0]   sample_t;
  typedef logic signed [OUT_W-1:0]   out_t;
  typedef logic        [COEF_W-1:0]  coef_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [GAIN_W-1:0] pole;
    logic [STEP_W-1:0] step_a;
    logic [STEP_W-1:0] step_v;
  } cfg_t;

  // controller -> lanes
  typedef struct packed {
    logic start;   // latch a sample and run the sequence
    logic retire;  // result taken by the output stage
  } lane_ctl_t;

  localparam state_t ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam state_t ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};
  localparam out_t   OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam out_t   OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // sample in milli-g to internal fixed point
  function automatic state_t widen(sample_t s);
    return {{(STATE_W-SMP_W-FRAC_W){s[SMP_W-1]}}, s, {FRAC_W{1'b0}}};
  endfunction

  // a + b or a - b, saturated to the state range
  function automatic state_t sat_add(state_t a, state_t b, logic sub);
    logic signed [STATE_W:0] ea;
    logic signed [STATE_W:0] eb;
    logic signed [STATE_W:0] s;
    ea = {a[STATE_W-1], a};
    eb = {b[STATE_W-1], b};
    s  = sub ? (ea - eb) : (ea + eb);
    if (s[STATE_W] != s[STATE_W-1]) begin
      return s[STATE_W] ? ST_MIN : ST_MAX;
    end
    return s[STATE_W-1:0];
  endfunction

  // a * c / 2^15 (q15 set) or 2^16, truncated toward zero, saturated
  function automatic state_t sat_mul(state_t a, coef_t c, logic q15);
    logic              neg;
    logic [STATE_W-1:0] mag;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  r;
    logic [PROD_W-1:0]  lim_p;
    logic [PROD_W-1:0]  lim_n;
    neg = a[STATE_W-1];
    mag = a;
    if (neg) begin
      mag = ~mag + {{(STATE_W-1){1'b0}}, 1'b1};
    end
    prod  = {{COEF_W{1'b0}}, mag} * {{STATE_W{1'b0}}, c};
    r     = q15 ? (prod >> SHIFT_Q15) : (prod >> SHIFT_Q16);
    lim_p = {{(PROD_W-STATE_W){1'b0}}, ST_MAX};
    lim_n = lim_p + {{(PROD_W-1){1'b0}}, 1'b1};
    if (!neg) begin
      return (r > lim_p) ? ST_MAX : r[STATE_W-1:0];
    end
    return (r > lim_n) ? ST_MIN : (~r[STATE_W-1:0] + {{(STATE_W-1){1'b0}}, 1'b1});
  endfunction

  // drop the fraction toward zero and saturate to the result range
  function automatic out_t to_out(state_t v);
    logic                       neg;
    logic [STATE_W-1:0]         mag;
    logic [STATE_W-FRAC_W-1:0]  ipart;
    logic [STATE_W-FRAC_W-1:0]  lim_p;
    logic [STATE_W-FRAC_W-1:0]  lim_n;
    neg = v[STATE_W-1];
    mag = v;
    if (neg) begin
      mag = ~mag + {{(STATE_W-1){1'b0}}, 1'b1};
    end
    ipart = mag[STATE_W-1:FRAC_W];
    lim_p = {{(STATE_W-FRAC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    lim_n = lim_p + {{(STATE_W-FRAC_W-1){1'b0}}, 1'b1};
    if (!neg) begin
      return (ipart > lim_p) ? OUT_MAX : ipart[OUT_W-1:0];
    end
    return (ipart > lim_n) ? OUT_MIN : (~ipart[OUT_W-1:0] + {{(OUT_W-1){1'b0}}, 1'b1});
  endfunction

endpackage

@@ sv/aden_if.sv @@
// ----------------------------------------------------------------------------
// aden_if
// Valid/ready channels of the estimator: acceleration words in,
// displacement words out.
// ----------------------------------------------------------------------------
interface aden_in_if;
  logic              valid;
  logic              ready;
  aden_pkg::sample_t accel_x_mg;
  aden_pkg::sample_t accel_y_mg;
  modport source (output valid, output accel_x_mg, output accel_y_mg, input ready);
  modport sink   (input valid, input accel_x_mg, input accel_y_mg, output ready);
endinterface

interface aden_out_if;
  logic           valid;
  logic           ready;
  aden_pkg::out_t disp_x_mm;
  aden_pkg::out_t disp_y_mm;
  modport source (output valid, output disp_x_mm, output disp_y_mm, input ready);
  modport sink   (input valid, input disp_x_mm, input disp_y_mm, output ready);
endinterface

@@ sv/accel_displacement_estimator.sv @@
// ----------------------------------------------------------------------------
// accel_displacement_estimator
// Two-axis displacement from acceleration: per axis a high-pass on
// acceleration, trapezoid to velocity, high-pass, trapezoid to displacement,
// high-pass, all in saturating signed Q31.16.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          word
//  -------  ---  -----------------  ------------------------------------------
//  in_ch    in   valid/ready        accel_x_mg, accel_y_mg (s16, milli-g)
//  out_ch   out  valid/ready        disp_x_mm, disp_y_mm (s24, mm)
//  cfg_*    in   write enable only  cfg_index selects gain/pole/step_a/step_v
//
//  One word in gives one word out. Each lane runs a 15-step sequence on its
//  own multiplier and adder; the multiply/add chain sets the rate.
//  The result moves to the output register once both lanes finish; the next
//  input is taken the cycle after that move, not while a word is in flight.
//  A stalled output holds the lanes finished, and input stays blocked.
//  rst_n (sync, low) zeroes all filter state and loads default coefficients.
//
module accel_displacement_estimator (
  input  logic                                clk,
  input  logic                                rst_n,
  aden_in_if.sink                             in_ch,
  aden_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [aden_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aden_pkg::CFG_DATA_W-1:0]     cfg_data
);

  aden_pkg::cfg_t    cfg_r;
  aden_pkg::lane_ctl_t ctl;
  aden_pkg::state_t  df_x, df_y;
  logic              busy_r;
  logic              accept;
  logic              done_x, done_y;
  logic              can_load;
  logic              load;

  // one word in flight; ready drops while the lanes hold it
  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;

  // both lanes run in lockstep; hand off when the output register has room
  assign load       = done_x && done_y && can_load;
  assign ctl.start  = accept;
  assign ctl.retire = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (load) begin
      busy_r <= 1'b0;
    end
  end

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain   <= aden_pkg::RST_HPF_GAIN;
      cfg_r.pole   <= aden_pkg::RST_HPF_POLE;
      cfg_r.step_a <= aden_pkg::RST_ACC_TO_VEL;
      cfg_r.step_v <= aden_pkg::RST_VEL_TO_DISP;
    end else if (cfg_we) begin
      case (cfg_index)
        aden_pkg::REG_HPF_GAIN:    cfg_r.gain   <= cfg_data[aden_pkg::GAIN_W-1:0];
        aden_pkg::REG_HPF_POLE:    cfg_r.pole   <= cfg_data[aden_pkg::GAIN_W-1:0];
        aden_pkg::REG_ACC_TO_VEL:  cfg_r.step_a <= cfg_data[aden_pkg::STEP_W-1:0];
        aden_pkg::REG_VEL_TO_DISP: cfg_r.step_v <= cfg_data[aden_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  aden_lane u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_ch.accel_x_mg),
    .cfg    (cfg_r),
    .done   (done_x),
    .df     (df_x)
  );

  aden_lane u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_ch.accel_y_mg),
    .cfg    (cfg_r),
    .done   (done_y),
    .df     (df_y)
  );

  aden_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .df_x      (df_x),
    .df_y      (df_y),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_x     (out_ch.disp_x_mm),
    .out_y     (out_ch.disp_y_mm),
    .can_load  (can_load)
  );

endmodule

@@ sv/aden_lane.sv @@
// ----------------------------------------------------------------------------
// aden_lane
// One axis: high-pass, trapezoid, high-pass, trapezoid, high-pass, run as a
// 15-step sequence on one saturating multiplier and one saturating adder.
// ----------------------------------------------------------------------------
module aden_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  aden_pkg::lane_ctl_t ctl,
  input  aden_pkg::sample_t   sample,
  input  aden_pkg::cfg_t      cfg,
  output logic                done,
  output aden_pkg::state_t    df
);

  localparam logic [3:0] S_ADIFF  = 4'd0;   // a - a_prev, q = p*af_prev
  localparam logic [3:0] S_AGAIN  = 4'd1;   // m = g*diff
  localparam logic [3:0] S_AF     = 4'd2;   // af = m + q
  localparam logic [3:0] S_ASUM   = 4'd3;   // af + af_prev, q = p*vf_prev
  localparam logic [3:0] S_ASTEP  = 4'd4;   // m = step_a*sum
  localparam logic [3:0] S_V      = 4'd5;   // v = v_acc + m
  localparam logic [3:0] S_VDIFF  = 4'd6;   // v - v_prev
  localparam logic [3:0] S_VGAIN  = 4'd7;
  localparam logic [3:0] S_VF     = 4'd8;
  localparam logic [3:0] S_VSUM   = 4'd9;   // vf + vf_prev, q = p*df_prev
  localparam logic [3:0] S_VSTEP  = 4'd10;
  localparam logic [3:0] S_D      = 4'd11;
  localparam logic [3:0] S_DDIFF  = 4'd12;
  localparam logic [3:0] S_DGAIN  = 4'd13;
  localparam logic [3:0] S_DF     = 4'd14;

  // filter and integrator state
  aden_pkg::sample_t pa_r;
  aden_pkg::state_t  paf_r, v_r, pvf_r, d_r, pdf_r;
  // working registers
  aden_pkg::sample_t smp_r;
  aden_pkg::state_t  x_r, m_r, q_r;
  logic [3:0]        step_r;
  logic              run_r, done_r;

  aden_pkg::state_t add_a, add_b, add_res, mul_a, mul_res;
  aden_pkg::coef_t  mul_c;
  logic add_sub, mul_q15;
  logic x_we, m_we, q_we, pa_we, paf_we, v_we, pvf_we, d_we, pdf_we;

  always_comb begin
    add_a   = x_r;
    add_b   = m_r;
    add_sub = 1'b0;
    mul_a   = x_r;
    mul_c   = {1'b0, cfg.gain};
    mul_q15 = 1'b1;
    x_we = 1'b0; m_we = 1'b0; q_we = 1'b0; pa_we = 1'b0; paf_we = 1'b0;
    v_we = 1'b0; pvf_we = 1'b0; d_we = 1'b0; pdf_we = 1'b0;
    if (run_r) begin
      case (step_r)
        S_ADIFF: begin
          add_a = aden_pkg::widen(smp_r); add_b = aden_pkg::widen(pa_r);
          add_sub = 1'b1; x_we = 1'b1; pa_we = 1'b1;
          mul_a = paf_r; mul_c = {1'b0, cfg.pole}; q_we = 1'b1;
        end
        S_AGAIN, S_VGAIN, S_DGAIN: begin
          m_we = 1'b1;
        end
        S_AF, S_VF: begin
          add_a = m_r; add_b = q_r; x_we = 1'b1;
        end
        S_ASUM: begin
          add_b = paf_r; x_we = 1'b1; paf_we = 1'b1;
          mul_a = pvf_r; mul_c = {1'b0, cfg.pole}; q_we = 1'b1;
        end
        S_ASTEP: begin
          mul_c = cfg.step_a; mul_q15 = 1'b0; m_we = 1'b1;
        end
        S_V: begin
          add_a = v_r; x_we = 1'b1;
        end
        S_VDIFF: begin
          add_b = v_r; add_sub = 1'b1; x_we = 1'b1; v_we = 1'b1;
        end
        S_VSUM: begin
          add_b = pvf_r; x_we = 1'b1; pvf_we = 1'b1;
          mul_a = pdf_r; mul_c = {1'b0, cfg.pole}; q_we = 1'b1;
        end
        S_VSTEP: begin
          mul_c = cfg.step_v; mul_q15 = 1'b0; m_we = 1'b1;
        end
        S_D: begin
          add_a = d_r; x_we = 1'b1;
        end
        S_DDIFF: begin
          add_b = d_r; add_sub = 1'b1; x_we = 1'b1; d_we = 1'b1;
        end
        S_DF: begin
          add_a = m_r; add_b = q_r; x_we = 1'b1; pdf_we = 1'b1;
        end
        default: begin
        end
      endcase
    end
    add_res = aden_pkg::sat_add(add_a, add_b, add_sub);
    mul_res = aden_pkg::sat_mul(mul_a, mul_c, mul_q15);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= S_ADIFF;
      pa_r   <= '0;
      paf_r  <= '0;
      v_r    <= '0;
      pvf_r  <= '0;
      d_r    <= '0;
      pdf_r  <= '0;
    end else begin
      if (ctl.start) begin
        run_r  <= 1'b1;
        step_r <= S_ADIFF;
      end else if (run_r) begin
        if (step_r == S_DF) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 4'd1;
      end
      if (ctl.retire) begin
        done_r <= 1'b0;
      end
      // state updates read the old value in the same step
      if (pa_we)  pa_r  <= smp_r;
      if (paf_we) paf_r <= x_r;
      if (v_we)   v_r   <= x_r;
      if (pvf_we) pvf_r <= x_r;
      if (d_we)   d_r   <= x_r;
      if (pdf_we) pdf_r <= add_res;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) smp_r <= sample;
    if (x_we)      x_r   <= add_res;
    if (m_we)      m_r   <= mul_res;
    if (q_we)      q_r   <= mul_res;
  end

  assign done = done_r;
  assign df   = pdf_r;

endmodule

@@ sv/aden_merge.sv @@
// ----------------------------------------------------------------------------
// aden_merge
// Output stage: takes both lanes' filtered displacement, drops the fraction,
// saturates, and holds the word until the sink takes it.
// ----------------------------------------------------------------------------
module aden_merge (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  aden_pkg::state_t df_x,
  input  aden_pkg::state_t df_y,
  input  logic             out_ready,
  output logic             out_valid,
  output aden_pkg::out_t   out_x,
  output aden_pkg::out_t   out_y,
  output logic             can_load
);

  logic           valid_r;
  aden_pkg::out_t x_r, y_r;

  assign can_load = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= aden_pkg::to_out(df_x);
      y_r <= aden_pkg::to_out(df_y);
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;

endmodule

@@ sv/aden_checker.sv @@
// ----------------------------------------------------------------------------
// aden_checker
// Port-level checks of the estimator's channels, bound to the top level.
// ----------------------------------------------------------------------------
module aden_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input aden_pkg::out_t out_x,
  input aden_pkg::out_t out_y
);

  // a word waiting at the output stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y))
    else $error("output word changed while stalled");

  // one word in flight: a taken input blocks the next cycle
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second input taken while busy");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind accel_displacement_estimator aden_checker u_aden_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.disp_x_mm),
  .out_y     (out_ch.disp_y_mm)
);
